// ----- design/dds_config_word_sequencer_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros shared by the sequencer modules
// ----------------------------------------------------------------------------
`ifndef DDS_CONFIG_WORD_SEQUENCER_MACROS_SVH
`define DDS_CONFIG_WORD_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DCWS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define DCWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/dcws_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcws_pkg
// types, constants and word formatting for the synthesizer word sequencer
// ----------------------------------------------------------------------------
package dcws_pkg;

	// field widths
	localparam int CfgW      = 25;
	localparam int FreqMagW  = 31;
	localparam int TuneW     = 28;
	localparam int PhaseW    = 12;
	localparam int PhaseClpW = 17;
	localparam int WordW     = 16;

	localparam logic [CfgW-1:0]      ClockDefault = 25'd25000000;
	localparam logic [TuneW-1:0]     TuningMax    = 28'h0FFFFFFF;
	localparam logic [PhaseClpW-1:0] PhaseFullQ8  = 17'd92160;

	// floor(2x/45) by reciprocal: exact for 2x up to 184320
	localparam logic [18:0] PhaseRecip = 19'd372828;

	// tuning divider: quotient bits per cycle and cycle count
	localparam int DivRadix = 4;
	localparam int DivSteps = TuneW / DivRadix;
	localparam int DivCntW  = $clog2(DivSteps);

	// control word bits
	localparam logic [WordW-1:0] B28Bit    = 16'h2000;
	localparam logic [WordW-1:0] ResetBit  = 16'h0100;
	localparam logic [WordW-1:0] TriBits   = 16'h0002;
	localparam logic [WordW-1:0] SqrBits   = 16'h0028;
	localparam logic [WordW-1:0] Freq0Sel  = 16'h4000;
	localparam logic [WordW-1:0] Phase0Sel = 16'hC000;

	// waveform codes
	localparam logic [1:0] WaveTri = 2'd1;
	localparam logic [1:0] WaveSqr = 2'd2;

	// how the tuning word is obtained
	typedef enum logic [1:0] {
		TUNE_ZERO,
		TUNE_SAT,
		TUNE_DIV
	} tune_kind_t;

	// position in the output sequence
	typedef enum logic [2:0] {
		WORD_CTRL_RST,
		WORD_FREQ_LO,
		WORD_FREQ_HI,
		WORD_PHASE,
		WORD_CTRL
	} word_idx_t;

	typedef enum logic {
		BK_IDLE,
		BK_SEND
	} bk_state_t;

	// classified request handed from front to back
	typedef struct packed {
		logic                  freq_cmd;
		logic [1:0]            wave;
		tune_kind_t            kind;
		logic [FreqMagW-1:0]   freq;
		logic [CfgW-1:0]       divisor;
		logic [PhaseW-1:0]     phase;
	} dcws_desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} dcws_fifo_stat_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [TuneW-1:0] quotient;
	} dcws_div_res_t;

	function automatic logic [WordW-1:0] dcws_wave_bits(logic [1:0] wave);
		logic [WordW-1:0] bits;
		unique case (wave)
			WaveTri: bits = TriBits;
			WaveSqr: bits = SqrBits;
			default: bits = '0;
		endcase
		return bits;
	endfunction

	function automatic logic [WordW-1:0] dcws_word(dcws_desc_t d, word_idx_t idx,
		logic [TuneW-1:0] tw);
		logic [WordW-1:0] ctrl;
		logic [WordW-1:0] w;
		ctrl = B28Bit | dcws_wave_bits(d.wave);
		unique case (idx)
			WORD_CTRL_RST: w = d.freq_cmd ? (ctrl | ResetBit) : ctrl;
			WORD_FREQ_LO:  w = Freq0Sel | {2'b00, tw[13:0]};
			WORD_FREQ_HI:  w = Freq0Sel | {2'b00, tw[27:14]};
			WORD_PHASE:    w = Phase0Sel | {4'b0000, d.phase};
			WORD_CTRL:     w = ctrl;
			default:       w = ctrl;
		endcase
		return w;
	endfunction

endpackage

// ----- design/dcws_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcws_divider
// iterative restoring divider for the 28-bit tuning word, four bits a cycle
// ----------------------------------------------------------------------------
module dcws_divider import dcws_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [FreqMagW-1:0] dividend,
	input  logic [CfgW-1:0]     divisor,
	output dcws_div_res_t       res
);

	logic               busy_q;
	logic               done_q;
	logic [DivCntW-1:0] cnt_q;
	logic [CfgW-1:0]    rem_q;
	logic [CfgW-1:0]    div_q;
	logic [TuneW-1:0]   bits_q;
	logic [TuneW-1:0]   quo_q;

	logic [CfgW-1:0]    rem_nxt;
	logic [TuneW-1:0]   bits_nxt;
	logic [TuneW-1:0]   quo_nxt;

	always_comb begin
		logic [CfgW:0] trial;
		rem_nxt  = rem_q;
		bits_nxt = bits_q;
		quo_nxt  = quo_q;
		for (int i = 0; i < DivRadix; i++) begin
			trial    = {rem_nxt, bits_nxt[TuneW-1]};
			bits_nxt = {bits_nxt[TuneW-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				trial   = trial - {1'b0, div_q};
				quo_nxt = {quo_nxt[TuneW-2:0], 1'b1};
			end else begin
				quo_nxt = {quo_nxt[TuneW-2:0], 1'b0};
			end
			rem_nxt = trial[CfgW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DivCntW'(DivSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient < 2^28 here, so the top 23 dividend bits already sit below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {2'b00, dividend[FreqMagW-1:8]};
			bits_q <= {dividend[7:0], 20'd0};
			quo_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= rem_nxt;
			bits_q <= bits_nxt;
			quo_q  <= quo_nxt;
		end
	end

	assign res.busy     = busy_q;
	assign res.done     = done_q;
	assign res.quotient = quo_q;

endmodule

// ----- design/dcws_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcws_fifo
// short request queue between front and back
// ----------------------------------------------------------------------------
`include "dds_config_word_sequencer_macros.svh"

module dcws_fifo import dcws_pkg::*; #(
	parameter int Depth = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dcws_desc_t      wdata,
	input  logic            pop,
	output dcws_desc_t      rdata,
	output dcws_fifo_stat_t stat
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	dcws_desc_t      entries_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

	assign rdata      = entries_q[rd_ptr_q];
	assign stat.full  = (count_q == CntW'(Depth));
	assign stat.empty = (count_q == '0);

	`DCWS_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CntW'(Depth), "queue count over depth")
	`DCWS_ASSERT_NEXT(a_push_fills, clk, arst_n, push && !pop, !stat.empty, "push left queue empty")
	`DCWS_ASSERT_IMPL(a_no_underflow, clk, arst_n, pop, !stat.empty, "pop from empty queue")

endmodule

// ----- design/dcws_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcws_front
// request intake: clamps, classifies the tuning case, scales the phase
// ----------------------------------------------------------------------------
module dcws_front import dcws_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                command,
	input  logic [1:0]          waveform,
	input  logic signed [31:0]  freq_q8,
	input  logic signed [17:0]  phase_q8,
	input  logic [CfgW-1:0]     master_clock_hz,
	input  logic                q_full,
	output logic                push,
	output dcws_desc_t          wdata
);

	logic                  valid_s1;
	logic                  cmd_s1;
	logic [1:0]            wave_s1;
	tune_kind_t            kind_s1;
	logic [FreqMagW-1:0]   freq_s1;
	logic [CfgW-1:0]       divisor_s1;
	logic [PhaseClpW:0]    ph2_s1;

	logic                  accept;
	logic [CfgW-1:0]       divisor;
	tune_kind_t            kind;
	logic [PhaseClpW-1:0]  ph_clamped;
	logic [PhaseClpW+19:0] ph_prod;

	assign divisor = (master_clock_hz == '0) ? ClockDefault : master_clock_hz;

	// quotient overflows 28 bits exactly when freq >= clock * 2^8
	always_comb begin
		if (freq_q8[31]) begin
			kind = TUNE_ZERO;
		end else if ({2'b00, freq_q8[30:0]} >= {divisor, 8'd0}) begin
			kind = TUNE_SAT;
		end else begin
			kind = TUNE_DIV;
		end
	end

	always_comb begin
		if (phase_q8[17]) begin
			ph_clamped = '0;
		end else if (phase_q8[16:0] > PhaseFullQ8) begin
			ph_clamped = PhaseFullQ8;
		end else begin
			ph_clamped = phase_q8[16:0];
		end
	end

	assign push     = valid_s1 && !q_full;
	assign in_ready = !valid_s1 || push;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= command;
			wave_s1    <= waveform;
			kind_s1    <= kind;
			freq_s1    <= freq_q8[30:0];
			divisor_s1 <= divisor;
			ph2_s1     <= {ph_clamped, 1'b0};
		end
	end

	// floor(2p/45) by reciprocal, 360 degrees wraps to zero through the mask
	assign ph_prod = ph2_s1 * PhaseRecip;

	assign wdata.freq_cmd = cmd_s1;
	assign wdata.wave     = wave_s1;
	assign wdata.kind     = kind_s1;
	assign wdata.freq     = freq_s1;
	assign wdata.divisor  = divisor_s1;
	assign wdata.phase    = ph_prod[35:24];

endmodule

// ----- design/dcws_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcws_back
// word emitter: runs the tuning division and sends the word sequence
// ----------------------------------------------------------------------------
`include "dds_config_word_sequencer_macros.svh"

module dcws_back import dcws_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  dcws_fifo_stat_t  q_stat,
	input  dcws_desc_t       q_head,
	output logic             pop,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [WordW-1:0] spi_word,
	output logic             last_word
);

	bk_state_t        state_q;
	bk_state_t        state_nxt;
	dcws_desc_t       cur_q;
	word_idx_t        idx_q;
	logic [TuneW-1:0] tune_q;
	logic             tune_ok_q;
	logic             out_valid_q;
	logic [WordW-1:0] spi_word_q;
	logic             last_word_q;

	logic             load;
	logic             is_last;
	logic             word_avail;
	logic             div_start;
	dcws_div_res_t    div_res;

	assign is_last    = (idx_q == (cur_q.freq_cmd ? WORD_CTRL : WORD_CTRL_RST));
	assign word_avail = (idx_q == WORD_CTRL_RST) || tune_ok_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					state_nxt = BK_SEND;
				end
			end
			BK_SEND: begin
				if (load && is_last && q_stat.empty) begin
					state_nxt = BK_IDLE;
				end
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	always_comb begin
		load      = 1'b0;
		pop       = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				pop = !q_stat.empty;
			end
			BK_SEND: begin
				load = word_avail && (!out_valid_q || out_ready);
				pop  = load && is_last && !q_stat.empty;
			end
			default: begin
				load = 1'b0;
				pop  = 1'b0;
			end
		endcase
		div_start = pop && q_head.freq_cmd && (q_head.kind == TUNE_DIV);
	end

	dcws_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (q_head.freq),
		.divisor  (q_head.divisor),
		.res      (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			idx_q       <= WORD_CTRL_RST;
			tune_ok_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (pop) begin
				idx_q     <= WORD_CTRL_RST;
				tune_ok_q <= !div_start;
			end else begin
				if (load) begin
					idx_q <= word_idx_t'(idx_q + 1'b1);
				end
				if (div_res.done) begin
					tune_ok_q <= 1'b1;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q  <= q_head;
			tune_q <= (q_head.kind == TUNE_SAT) ? TuningMax : '0;
		end else if (div_res.done) begin
			tune_q <= div_res.quotient;
		end
		if (load) begin
			spi_word_q  <= dcws_word(cur_q, idx_q, tune_q);
			last_word_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign spi_word  = spi_word_q;
	assign last_word = last_word_q;

	`DCWS_ASSERT_IMPL(a_div_idle_at_start, clk, arst_n, div_start, !div_res.busy, "divider restarted while busy")
	`DCWS_ASSERT_IMPL(a_done_while_pending, clk, arst_n, div_res.done, (state_q == BK_SEND) && !tune_ok_q, "tuning result with no request waiting")
	`DCWS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid_q && !out_ready, out_valid_q && $stable(spi_word_q), "stalled word dropped or changed")

endmodule

// ----- design/dds_config_word_sequencer.sv -----
// a request passes the front register, the queue and the back end's request register
// before its first word is registered; set-wave requests: one per cycle while nothing
// stalls; set-frequency requests wait for the divider when the tuning word is neither
// zero nor saturated (four quotient bits per cycle, started when the back end takes it)
// reset: asynchronous active-low; clears the queue, pipeline and output valid and
// loads the reference clock register with 25000000
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_config_word_sequencer
// turns waveform and frequency/phase requests into 16-bit synthesizer words
// ----------------------------------------------------------------------------
module dds_config_word_sequencer import dcws_pkg::*; #(
	parameter int FifoDepth = 2
) (
	input  logic                clk,
	input  logic                arst_n,

	// configuration: reference clock in hertz
	input  logic                cfg_wr_en,
	input  logic [CfgW-1:0]     cfg_wr_data,

	// request channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                command,
	input  logic [1:0]          waveform,
	input  logic signed [31:0]  freq_q8,
	input  logic signed [17:0]  phase_q8,

	// word channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic [WordW-1:0]    spi_word,
	output logic                last_word
);

	// reference clock register; zero is replaced by the default in the front
	logic [CfgW-1:0] master_clock_hz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_clock_hz_q <= ClockDefault;
		end else if (cfg_wr_en) begin
			master_clock_hz_q <= cfg_wr_data;
		end
	end

	// front to queue
	logic            q_push;
	dcws_desc_t      q_wdata;

	// queue to back
	logic            q_pop;
	dcws_desc_t      q_head;
	dcws_fifo_stat_t q_stat;

	// front: one transaction per cycle while the queue has room, classifies the tuning case and scales phase
	dcws_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.command         (command),
		.waveform        (waveform),
		.freq_q8         (freq_q8),
		.phase_q8        (phase_q8),
		.master_clock_hz (master_clock_hz_q),
		.q_full          (q_stat.full),
		.push            (q_push),
		.wdata           (q_wdata)
	);

	// queue lets the front keep taking requests while the back divides or stalls
	dcws_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_head),
		.stat   (q_stat)
	);

	// back: divider plus output register, one word per output transaction
	dcws_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.q_head    (q_head),
		.pop       (q_pop),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.spi_word  (spi_word),
		.last_word (last_word)
	);

endmodule

// ----- dv/dds_config_word_sequencer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_config_word_sequencer_tb
// drives waveform and frequency/phase requests into the word sequencer under
// several reference clock settings, predicts every synthesizer word in a
// scoreboard and compares each word transaction against the oldest prediction
// ----------------------------------------------------------------------------
module dds_config_word_sequencer_tb;
	import dcws_pkg::*;

	// request codes
	localparam logic       CmdWave       = 1'b0;
	localparam logic       CmdFreqPhase  = 1'b1;
	localparam logic [1:0] WaveSine      = 2'd0;
	localparam logic [1:0] WaveSineAlias = 2'd3;

	// full turn of 360 degrees in q8 degrees
	localparam int FullTurnQ8 = 92160;
	// quiet cycles before giving up, and pause before a register write or the end
	localparam int QuietLimit = 2000;
	localparam int DrainPause = 20;
	localparam int PhaseItems = 40;

	typedef struct packed {
		logic [WordW-1:0] word;
		logic             last;
	} spi_exp_t;

	// predicts the words of each request and checks arriving words in order
	class dds_word_scoreboard;
		logic [CfgW-1:0] clock_hz = ClockDefault;
		spi_exp_t        pending_words[$];
		int              errors = 0;

		function void set_clock(logic [CfgW-1:0] value);
			clock_hz = value;
		endfunction

		function int pending();
			return pending_words.size();
		endfunction

		function void push_word(logic [WordW-1:0] word, logic last);
			spi_exp_t w;
			w.word = word;
			w.last = last;
			pending_words.push_back(w);
		endfunction

		function void note_request(logic cmd, logic [1:0] wave, logic signed [31:0] freq,
			logic signed [17:0] phase);
			logic [WordW-1:0] ctrl;
			logic [63:0]      divisor;
			logic [63:0]      tuning;
			int               deg;
			int               pw;
			case (wave)
				WaveTri: ctrl = B28Bit | TriBits;
				WaveSqr: ctrl = B28Bit | SqrBits;
				default: ctrl = B28Bit;
			endcase
			if (cmd == CmdWave) begin
				push_word(ctrl, 1'b1);
				return;
			end
			divisor = (clock_hz != '0) ? {39'd0, clock_hz} : {39'd0, ClockDefault};
			if (freq < 0) begin
				tuning = '0;
			end else begin
				tuning = ({32'd0, freq} << 20) / divisor;
				if (tuning > {36'd0, TuningMax})
					tuning = {36'd0, TuningMax};
			end
			if (phase < 0)
				deg = 0;
			else if (phase > FullTurnQ8)
				deg = FullTurnQ8;
			else
				deg = int'(phase);
			pw = (deg * 4096 / FullTurnQ8) & 32'h0FFF;
			push_word(ctrl | ResetBit, 1'b0);
			push_word(Freq0Sel | {2'b00, tuning[13:0]}, 1'b0);
			push_word(Freq0Sel | {2'b00, tuning[27:14]}, 1'b0);
			push_word(Phase0Sel | {4'b0000, pw[11:0]}, 1'b0);
			push_word(ctrl, 1'b1);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_word(logic [WordW-1:0] word, logic last);
			spi_exp_t w;
			if (pending_words.size() == 0) begin
				report($sformatf("word %h last %b with nothing pending", word, last));
				return;
			end
			w = pending_words.pop_front();
			if (word !== w.word)
				report($sformatf("spi_word %h, predicted %h", word, w.word));
			if (last !== w.last)
				report($sformatf("last_word %b, predicted %b (word %h)", last, w.last, w.word));
		endtask
	endclass

	// dut inputs, all known from time zero
	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                cfg_wr_en   = 1'b0;
	logic [CfgW-1:0]     cfg_wr_data = '0;
	logic                in_valid    = 1'b0;
	logic                in_ready;
	logic                command     = 1'b0;
	logic [1:0]          waveform    = '0;
	logic signed [31:0]  freq_q8     = '0;
	logic signed [17:0]  phase_q8    = '0;
	logic                out_valid;
	logic                out_ready   = 1'b0;
	logic [WordW-1:0]    spi_word;
	logic                last_word;

	dds_word_scoreboard words = new();

	// no idling on either side once set
	logic calm        = 1'b0;
	int   stall_left  = 0;
	int   quiet_count = 0;

	always #5 clk = ~clk;

	dds_config_word_sequencer DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.waveform   (waveform),
		.freq_q8    (freq_q8),
		.phase_q8   (phase_q8),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.spi_word   (spi_word),
		.last_word  (last_word)
	);

	// word sink: check each word transaction, then pick ready for the next cycle
	always @(posedge clk) begin
		if (out_valid && out_ready)
			words.check_word(spi_word, last_word);
		if (calm) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 7) == 0) begin
			// start a stall burst here; stall_left holds the rest of its length
			stall_left = $urandom_range(1, 17) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// watchdog: any transaction on either channel restarts the count
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_count <= 0;
		else
			quiet_count <= quiet_count + 1;
		if (quiet_count >= QuietLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// one request transaction, with an optional idle burst in front of it
	task automatic send_request(input logic cmd, input logic [1:0] wave,
		input logic signed [31:0] freq, input logic signed [17:0] phase);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 17);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		waveform <= wave;
		freq_q8  <= freq;
		phase_q8 <= phase;
		do @(posedge clk); while (!in_ready);
		words.note_request(cmd, wave, freq, phase);
	endtask

	// mostly frequency/phase requests, frequency and phase drawn from a few ranges
	task automatic random_request();
		logic               cmd;
		logic [1:0]         wave;
		logic signed [31:0] freq;
		logic signed [17:0] phase;
		logic [63:0]        edge_freq;
		cmd  = ($urandom_range(0, 3) != 0) ? CmdFreqPhase : CmdWave;
		wave = 2'($urandom_range(0, 3));
		case ($urandom_range(0, 3))
			0: freq = $urandom;
			1: freq = $urandom & 32'h7FFF_FFFF;
			2: freq = $urandom_range(0, 1 << 24);
			default: begin
				// around the point where the tuning word saturates, when reachable
				if (words.clock_hz != '0 && words.clock_hz < 25'd8388608) begin
					edge_freq = {39'd0, words.clock_hz} * 256 - 1 + $urandom_range(0, 2);
					freq = edge_freq[31:0];
				end else begin
					freq = $urandom;
				end
			end
		endcase
		case ($urandom_range(0, 3))
			0, 1: phase = 18'($urandom_range(0, FullTurnQ8));
			2: phase = 18'($urandom);
			default: phase = 18'(FullTurnQ8 - 2 + $urandom_range(0, 4));
		endcase
		send_request(cmd, wave, freq, phase);
	endtask

	// wait for every predicted word, then let the divider settle
	task automatic drain();
		while (words.pending() != 0) @(posedge clk);
		repeat (DrainPause) @(posedge clk);
	endtask

	// reference clock write, only with the block drained
	task automatic write_clock(input logic [CfgW-1:0] value);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		words.set_clock(value);
	endtask

	task automatic random_phase(input int n);
		repeat (n) random_request();
		in_valid <= 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every waveform code as a set-wave request
		send_request(CmdWave, WaveSine, -32'sd1, -18'sd1);
		send_request(CmdWave, WaveTri, 32'sd0, 18'sd0);
		send_request(CmdWave, WaveSqr, 32'h7FFF_FFFF, 18'sd131071);
		send_request(CmdWave, WaveSineAlias, 32'h8000_0000, -18'sd131072);
		// directed: frequency/phase extremes at the reset clock
		send_request(CmdFreqPhase, WaveTri, 32'sd256000, 18'sd46080);
		send_request(CmdFreqPhase, WaveSqr, 32'sd0, 18'sd0);
		// negative frequency and negative phase clamp to zero
		send_request(CmdFreqPhase, WaveSine, -32'sd1, -18'sd1);
		send_request(CmdFreqPhase, WaveSineAlias, 32'h8000_0000, -18'sd131072);
		// largest frequency, phase far above a full turn
		send_request(CmdFreqPhase, WaveTri, 32'h7FFF_FFFF, 18'sd131071);
		// exactly a full turn wraps to phase word zero
		send_request(CmdFreqPhase, WaveSqr, 32'sd6400, 18'sd92160);
		send_request(CmdFreqPhase, WaveSine, 32'sd1, 18'sd92159);
		send_request(CmdFreqPhase, WaveTri, 32'sd100, 18'sd92161);
		send_request(CmdFreqPhase, WaveSqr, 32'sd12345678, 18'sd5760);
		random_phase(PhaseItems);

		// slowest clock: most frequencies saturate the tuning word
		write_clock(25'd1);
		send_request(CmdFreqPhase, WaveTri, 32'sd255, 18'sd0);
		send_request(CmdFreqPhase, WaveSqr, 32'sd256, 18'sd0);
		random_phase(PhaseItems);

		// fastest clock
		write_clock(25'h1FF_FFFF);
		send_request(CmdFreqPhase, WaveSine, 32'h7FFF_FFFF, 18'sd1);
		random_phase(PhaseItems);

		// zero clock falls back to the reset value
		write_clock(25'd0);
		random_phase(PhaseItems);

		// small clock, saturation edge reachable
		write_clock(25'd1000);
		random_phase(PhaseItems);

		write_clock(25'($urandom_range(2, 25'h1FF_FFFE)));
		random_phase(PhaseItems);

		// back to the reset clock, no idling on either side
		write_clock(ClockDefault);
		calm = 1'b1;
		random_phase(PhaseItems);

		drain();
		if (words.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
